@@ rtl/aopb_pkg.sv @@
// Shared widths, limits and register codes for the alpha-over pixel blender.
`timescale 1ns / 1ps

package aopb_pkg;

  // Canvas and coordinate geometry
  localparam int unsigned MAX_DIM   = 8192;
  localparam int unsigned DIM_W     = 14;
  localparam int unsigned COORD_W   = 15;
  localparam int unsigned ADDR_W    = 26;

  // Pixel packing
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned NUM_CHAN  = 3;

  // Per-channel divider: numerator and quotient widths
  localparam int unsigned NUM_W     = 17;
  localparam int unsigned QUO_W     = 9;
  localparam int unsigned DIV_STEPS = 3;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CANVAS_WIDTH  = 2'd0,
    CFG_CANVAS_HEIGHT = 2'd1
  } cfg_reg_e;

endpackage

@@ rtl/aopb_div.sv @@
// Three-stage restoring divider for one color channel, three quotient bits per stage.
`timescale 1ns / 1ps

module aopb_div (
  input  logic                           clk_i,
  input  logic [aopb_pkg::NUM_W-1:0]     num_i,
  input  logic [aopb_pkg::CHAN_W-1:0]    den_i,
  output logic [aopb_pkg::QUO_W-1:0]     quo_o
);

  typedef struct packed {
    logic [aopb_pkg::CHAN_W-1:0] rem;
    logic [aopb_pkg::CHAN_W-1:0] den;
    logic [aopb_pkg::QUO_W-1:0]  quo;
    logic [aopb_pkg::QUO_W-1:0]  low;
  } div_stage_t;

  typedef struct packed {
    logic [aopb_pkg::CHAN_W-1:0]    rem;
    logic [aopb_pkg::DIV_STEPS-1:0] bits;
  } step_res_t;

  // Run three restoring steps: shift in a dividend bit, subtract when it fits
  function automatic step_res_t div_steps(input logic [aopb_pkg::CHAN_W-1:0]    rem,
                                          input logic [aopb_pkg::DIV_STEPS-1:0] din,
                                          input logic [aopb_pkg::CHAN_W-1:0]    den);
    step_res_t                 res;
    logic [aopb_pkg::CHAN_W:0] wide;
    res.rem  = rem;
    res.bits = '0;
    for (int i = aopb_pkg::DIV_STEPS - 1; i >= 0; i--) begin
      wide = {res.rem, din[i]};
      if (wide >= {1'b0, den}) begin
        wide        = wide - {1'b0, den};
        res.bits[i] = 1'b1;
      end
      res.rem = wide[aopb_pkg::CHAN_W-1:0];
    end
    return res;
  endfunction

  div_stage_t st0_d, st0_q;
  div_stage_t st1_d, st1_q;
  div_stage_t st2_d, st2_q;
  step_res_t  r0, r1, r2;

  // Stage 0: top quotient bits
  always_comb begin
    r0        = div_steps(num_i[aopb_pkg::NUM_W-1:aopb_pkg::QUO_W], num_i[8:6], den_i);
    st0_d.rem = r0.rem;
    st0_d.den = den_i;
    st0_d.quo = {r0.bits, 6'd0};
    st0_d.low = {3'd0, num_i[5:0]};
  end

  // Stage 1: middle quotient bits
  always_comb begin
    r1        = div_steps(st0_q.rem, st0_q.low[5:3], st0_q.den);
    st1_d.rem = r1.rem;
    st1_d.den = st0_q.den;
    st1_d.quo = {st0_q.quo[8:6], r1.bits, 3'd0};
    st1_d.low = st0_q.low;
  end

  // Stage 2: low quotient bits
  always_comb begin
    r2        = div_steps(st1_q.rem, st1_q.low[2:0], st1_q.den);
    st2_d.rem = r2.rem;
    st2_d.den = st1_q.den;
    st2_d.quo = {st1_q.quo[8:3], r2.bits};
    st2_d.low = st1_q.low;
  end

  // Advance the stages every cycle
  always_ff @(posedge clk_i) begin
    st0_q <= st0_d;
    st1_q <= st1_d;
    st2_q <= st2_d;
  end

  assign quo_o = st2_q.quo;

endmodule

@@ rtl/alpha_over_pixel_blend.sv @@
// Top level: clips a pixel, computes its address and blends source over destination.
// done_o is registered alongside the result fields and is high in the same cycle as them.
// Throughput: one pixel per cycle; busy_o stays low, the result receiver cannot stall.
// Stages: clip and products, alpha divide and address, channel divide-by-255, sum,
// three radix-8 divider stages for the channel divide by output alpha, output register.
// Reset: rst_ni clears the valid pipeline and sets both canvas dimensions to 8192.
`timescale 1ns / 1ps

module alpha_over_pixel_blend (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [aopb_pkg::COORD_W-1:0]       x_pos_i,
  input  logic [aopb_pkg::COORD_W-1:0]       y_pos_i,
  input  logic [aopb_pkg::COLOR_W-1:0]       src_color_i,
  input  logic [aopb_pkg::COLOR_W-1:0]       dst_color_i,
  output logic                               done_o,
  output logic                               write_enable_o,
  output logic [aopb_pkg::ADDR_W-1:0]        pixel_address_o,
  output logic [aopb_pkg::COLOR_W-1:0]       out_color_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [aopb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [aopb_pkg::DIM_W-1:0]         cfg_data_i
);

  localparam int unsigned LATENCY = 8;
  localparam int unsigned NSTAGE  = 7;

  typedef struct packed {
    logic                              wr;
    logic                              copy;
    logic [aopb_pkg::COLOR_W-1:0]      src;
    logic [aopb_pkg::CHAN_W-1:0]       oa;
    logic [aopb_pkg::ADDR_W-1:0]       addr;
  } meta_t;

  typedef struct packed {
    logic                              wr;
    logic                              copy;
    logic [12:0]                       x;
    logic [12:0]                       y;
    logic [aopb_pkg::COLOR_W-1:0]      src;
    logic [aopb_pkg::CHAN_W-1:0]       oma;
    logic [15:0]                       noa;
    logic [2:0][15:0]                  sa;
    logic [2:0][15:0]                  dp;
  } s1_t;

  typedef struct packed {
    meta_t                             m;
    logic [2:0][15:0]                  sa;
    logic [2:0][23:0]                  tn;
  } s2_t;

  typedef struct packed {
    meta_t                             m;
    logic [2:0][15:0]                  sa;
    logic [2:0][15:0]                  t;
  } s3_t;

  typedef struct packed {
    meta_t                             m;
    logic [2:0][aopb_pkg::NUM_W-1:0]   num;
  } s4_t;

  // Floor division by 255 through a 257/65536 reciprocal and one correction step
  function automatic logic [15:0] div255(input logic [23:0] n);
    logic [32:0] prod;
    logic [15:0] q0;
    logic [23:0] rem;
    prod = {9'd0, n} + {1'b0, n, 8'd0};
    q0   = prod[31:16];
    rem  = n - 24'(q0) * 24'd255;
    if (rem >= 24'd255) begin
      return q0 + 16'd1;
    end
    return q0;
  endfunction

  // Configuration registers
  logic [aopb_pkg::DIM_W-1:0] cfg_w_q, cfg_h_q, cfg_val;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  // Clamp oversize dimensions
  assign cfg_val = (cfg_data_i > aopb_pkg::DIM_W'(aopb_pkg::MAX_DIM))
                 ? aopb_pkg::DIM_W'(aopb_pkg::MAX_DIM) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= aopb_pkg::DIM_W'(aopb_pkg::MAX_DIM);
      cfg_h_q <= aopb_pkg::DIM_W'(aopb_pkg::MAX_DIM);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        aopb_pkg::CFG_CANVAS_WIDTH:  cfg_w_q <= cfg_val;
        aopb_pkg::CFG_CANVAS_HEIGHT: cfg_h_q <= cfg_val;
        default: ;
      endcase
    end
  end

  // Valid pipeline
  logic [NSTAGE-1:0] vld_d, vld_q;
  logic              done_q;

  assign vld_d = {vld_q[NSTAGE-2:0], start_i && !busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      done_q <= vld_q[NSTAGE-1];
    end
  end

  // Stage 1: clip, flags and channel products
  s1_t                         s1_d, s1_q;
  logic [aopb_pkg::CHAN_W-1:0] a_in, da_in;
  logic                        x_in, y_in;

  always_comb begin
    a_in    = src_color_i[31:24];
    da_in   = dst_color_i[31:24];
    x_in    = !x_pos_i[aopb_pkg::COORD_W-1] && (x_pos_i[aopb_pkg::DIM_W-1:0] < cfg_w_q);
    y_in    = !y_pos_i[aopb_pkg::COORD_W-1] && (y_pos_i[aopb_pkg::DIM_W-1:0] < cfg_h_q);
    s1_d.wr   = x_in && y_in && (a_in != 8'd0);
    s1_d.copy = (a_in == 8'hFF) || (da_in == 8'd0);
    s1_d.x    = x_pos_i[12:0];
    s1_d.y    = y_pos_i[12:0];
    s1_d.src  = src_color_i;
    s1_d.oma  = 8'hFF - a_in;
    s1_d.noa  = {8'd0, da_in} * {8'd0, s1_d.oma} + 16'd127;
    for (int c = 0; c < aopb_pkg::NUM_CHAN; c++) begin
      s1_d.sa[c] = {8'd0, src_color_i[c*8 +: 8]} * {8'd0, a_in};
      s1_d.dp[c] = {8'd0, dst_color_i[c*8 +: 8]} * {8'd0, da_in};
    end
  end

  // Stage 2: output alpha, address and destination numerators
  s2_t         s2_d, s2_q;
  logic [15:0] oa_q0;
  logic [26:0] addr_full;

  always_comb begin
    oa_q0       = div255({8'd0, s1_q.noa});
    addr_full   = 27'(s1_q.y) * 27'(cfg_w_q) + 27'(s1_q.x);
    s2_d.m.wr   = s1_q.wr;
    s2_d.m.copy = s1_q.copy;
    s2_d.m.src  = s1_q.src;
    s2_d.m.oa   = s1_q.src[31:24] + oa_q0[7:0];
    s2_d.m.addr = addr_full[aopb_pkg::ADDR_W-1:0];
    s2_d.sa     = s1_q.sa;
    for (int c = 0; c < aopb_pkg::NUM_CHAN; c++) begin
      s2_d.tn[c] = {8'd0, s1_q.dp[c]} * {16'd0, s1_q.oma} + 24'd127;
    end
  end

  // Stage 3: scale destination terms by 1/255
  s3_t s3_d, s3_q;

  always_comb begin
    s3_d.m  = s2_q.m;
    s3_d.sa = s2_q.sa;
    for (int c = 0; c < aopb_pkg::NUM_CHAN; c++) begin
      s3_d.t[c] = div255(s2_q.tn[c]);
    end
  end

  // Stage 4: sum source, destination and rounding terms
  s4_t s4_d, s4_q;

  always_comb begin
    s4_d.m = s3_q.m;
    for (int c = 0; c < aopb_pkg::NUM_CHAN; c++) begin
      s4_d.num[c] = {1'b0, s3_q.sa[c]} + {1'b0, s3_q.t[c]}
                  + {10'd0, s3_q.m.oa[7:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
    s3_q <= s3_d;
    s4_q <= s4_d;
  end

  // Stages 5 to 7: divide each channel by output alpha
  logic [2:0][aopb_pkg::QUO_W-1:0] quo;

  for (genvar c = 0; c < aopb_pkg::NUM_CHAN; c++) begin : g_div
    aopb_div u_div (
      .clk_i (clk_i),
      .num_i (s4_q.num[c]),
      .den_i (s4_q.m.oa),
      .quo_o (quo[c])
    );
  end

  // Delay the side data alongside the dividers
  meta_t meta_d [3];
  meta_t meta_q [3];

  assign meta_d[0] = s4_q.m;
  assign meta_d[1] = meta_q[0];
  assign meta_d[2] = meta_q[1];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      meta_q[i] <= meta_d[i];
    end
  end

  // Output stage: saturate, pick copy or blend, zero a dropped pixel
  logic                          we_d, we_q;
  logic [aopb_pkg::ADDR_W-1:0]   addr_d, addr_q;
  logic [aopb_pkg::COLOR_W-1:0]  color_d, color_q, blend;

  always_comb begin
    blend[31:24] = meta_q[2].oa;
    for (int c = 0; c < aopb_pkg::NUM_CHAN; c++) begin
      blend[c*8 +: 8] = quo[c][aopb_pkg::QUO_W-1] ? 8'hFF : quo[c][7:0];
    end
    we_d    = meta_q[2].wr;
    addr_d  = meta_q[2].wr ? meta_q[2].addr : '0;
    color_d = !meta_q[2].wr ? '0 : (meta_q[2].copy ? meta_q[2].src : blend);
  end

  always_ff @(posedge clk_i) begin
    we_q    <= we_d;
    addr_q  <= addr_d;
    color_q <= color_d;
  end

  assign done_o          = done_q;
  assign write_enable_o  = we_q;
  assign pixel_address_o = addr_q;
  assign out_color_o     = color_q;

  // Checks
  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !write_enable_o) |-> (pixel_address_o == '0 && out_color_o == '0))
    else $error("dropped pixel carries nonzero fields");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without accepted transaction");

  a_cfg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_w_q <= aopb_pkg::DIM_W'(aopb_pkg::MAX_DIM))
      && (cfg_h_q <= aopb_pkg::DIM_W'(aopb_pkg::MAX_DIM)))
    else $error("canvas dimension above limit");

endmodule
